// ===== src/xml_entity_unescape_defines.svh =====
// ----------------------------------------------------------------------------
// XML entity decoder: assertion macros
// Shared wrappers for the concurrent checks on the decoder ports.
// ----------------------------------------------------------------------------
`ifndef XML_ENTITY_UNESCAPE_DEFINES_SVH
`define XML_ENTITY_UNESCAPE_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define XEU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define XEU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/xeu_pkg.sv =====
// ----------------------------------------------------------------------------
// XML entity decoder package
// Payload types, entity table and sizes shared by the decoder files.
// ----------------------------------------------------------------------------
package xeu_pkg;

	localparam int HOLD_DEPTH = 5;          // longest proper entity prefix
	localparam int MAX_RES    = 6;          // held bytes plus one
	localparam int NUM_ENT    = 5;
	localparam int ENT_MAXLEN = 6;
	localparam int CNT_W      = 3;          // holds 0..MAX_RES

	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_LT  = 8'h3c;
	localparam logic [7:0] CH_GT  = 8'h3e;

	// &quot; &apos; &lt; &gt; &amp; (short ones padded)
	localparam logic [7:0] ENT_TEXT [NUM_ENT][ENT_MAXLEN] = '{
		'{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},
		'{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},
		'{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
		'{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
		'{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00}
	};
	localparam logic [CNT_W-1:0] ENT_LEN [NUM_ENT] = '{3'd6, 3'd6, 3'd4, 3'd4, 3'd5};
	localparam logic [7:0] ENT_CHAR [NUM_ENT] = '{8'h22, 8'h27, 8'h3c, 8'h3e, 8'h26};

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       bad_sequence;
	} out_t;

	// state update and result count from one decode step
	typedef struct packed {
		logic [CNT_W-1:0] res_cnt;
		logic             mb_we;
		logic [2:0]       mb_idx;
		logic [7:0]       mb_wdata;
		logic [CNT_W-1:0] mc_next;
		logic             drop_next;
	} step_ctl_t;

endpackage

// ===== src/xeu_step.sv =====
// ----------------------------------------------------------------------------
// XML entity decoder: step logic
// Matches one byte against the held partial entity and builds the results.
// ----------------------------------------------------------------------------
module xeu_step (
	input  logic [7:0]                  c,
	input  logic                        last,
	input  logic                        strict,
	input  logic                        drop,
	input  logic [xeu_pkg::CNT_W-1:0]   mc,
	input  logic [7:0]                  mb [xeu_pkg::HOLD_DEPTH],
	output xeu_pkg::step_ctl_t          ctl,
	output xeu_pkg::out_t               res [xeu_pkg::MAX_RES]
);

	logic [xeu_pkg::CNT_W-1:0] n;
	logic [xeu_pkg::CNT_W-1:0] n1;
	logic [7:0]                cand [xeu_pkg::ENT_MAXLEN];
	logic [xeu_pkg::NUM_ENT-1:0] pm;
	logic [xeu_pkg::NUM_ENT-1:0] full;
	logic [7:0]                ch;
	logic [xeu_pkg::CNT_W-1:0] p;
	xeu_pkg::out_t             tail;
	logic                      tail_v;
	logic                      fresh;

	always_comb begin
		n  = (mc > xeu_pkg::CNT_W'(xeu_pkg::HOLD_DEPTH)) ? '0 : mc;
		n1 = n + xeu_pkg::CNT_W'(1);
		for (int i = 0; i < xeu_pkg::ENT_MAXLEN; i++)
			cand[i] = c;
		for (int i = 0; i < xeu_pkg::HOLD_DEPTH; i++) begin
			if (xeu_pkg::CNT_W'(i) < n)
				cand[i] = mb[i];
		end
		ch = '0;
		for (int e = 0; e < xeu_pkg::NUM_ENT; e++) begin
			pm[e] = (n1 <= xeu_pkg::ENT_LEN[e]);
			for (int i = 0; i < xeu_pkg::ENT_MAXLEN; i++) begin
				if (xeu_pkg::CNT_W'(i) <= n && cand[i] != xeu_pkg::ENT_TEXT[e][i])
					pm[e] = 1'b0;
			end
			full[e] = pm[e] && (n1 == xeu_pkg::ENT_LEN[e]);
			if (full[e])
				ch = xeu_pkg::ENT_CHAR[e];
		end
	end

	always_comb begin
		p             = '0;
		tail          = '0;
		tail_v        = 1'b0;
		fresh         = 1'b0;
		ctl.mb_we     = 1'b0;
		ctl.mb_idx    = n;
		ctl.mb_wdata  = c;
		ctl.mc_next   = n;
		ctl.drop_next = 1'b0;

		if (drop) begin
			ctl.drop_next = !last;
		end else if (n != '0) begin
			if (|full) begin
				tail        = '{out_byte: ch, out_last: last, bad_sequence: 1'b0};
				tail_v      = 1'b1;
				ctl.mc_next = '0;
			end else if (|pm && n < xeu_pkg::CNT_W'(xeu_pkg::HOLD_DEPTH)) begin
				ctl.mb_we   = 1'b1;
				ctl.mc_next = n1;
				if (last) begin
					ctl.mc_next = '0;
					tail_v      = 1'b1;
					if (strict) begin
						tail = '{out_byte: 8'h00, out_last: 1'b1, bad_sequence: 1'b1};
					end else begin
						p    = n;
						tail = '{out_byte: c, out_last: 1'b1, bad_sequence: 1'b0};
					end
				end
			end else if (strict) begin
				tail          = '{out_byte: 8'h00, out_last: 1'b1, bad_sequence: 1'b1};
				tail_v        = 1'b1;
				ctl.mc_next   = '0;
				ctl.drop_next = !last;
			end else begin
				p           = n;
				ctl.mc_next = '0;
				fresh       = 1'b1;
			end
		end else begin
			fresh = 1'b1;
		end

		// current byte taken afresh
		if (fresh) begin
			if (c == xeu_pkg::CH_AMP) begin
				ctl.mb_we   = 1'b1;
				ctl.mb_idx  = '0;
				ctl.mc_next = 3'd1;
				if (last) begin
					ctl.mc_next = '0;
					tail_v      = 1'b1;
					if (strict) begin
						tail = '{out_byte: 8'h00, out_last: 1'b1, bad_sequence: 1'b1};
					end else begin
						tail = '{out_byte: c, out_last: 1'b1, bad_sequence: 1'b0};
					end
				end
			end else if (strict && (c == xeu_pkg::CH_LT || c == xeu_pkg::CH_GT)) begin
				tail          = '{out_byte: 8'h00, out_last: 1'b1, bad_sequence: 1'b1};
				tail_v        = 1'b1;
				ctl.mc_next   = '0;
				ctl.drop_next = !last;
			end else begin
				tail   = '{out_byte: c, out_last: last, bad_sequence: 1'b0};
				tail_v = 1'b1;
			end
		end

		ctl.res_cnt = p + xeu_pkg::CNT_W'(tail_v);
	end

	always_comb begin
		for (int i = 0; i < xeu_pkg::HOLD_DEPTH; i++) begin
			if (xeu_pkg::CNT_W'(i) < p) begin
				res[i] = '{out_byte: mb[i], out_last: 1'b0, bad_sequence: 1'b0};
			end else begin
				res[i] = tail;
			end
		end
		res[xeu_pkg::MAX_RES-1] = tail;
	end

endmodule

// ===== src/xml_entity_unescape.sv =====
// ----------------------------------------------------------------------------
// XML entity decoder, top level
// Streams bytes through and replaces the five predefined XML entities.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per byte, in_last on the final byte of a message.
//   out_* : decoded bytes; bad_sequence marks the single error result that
//           closes an aborted message in strict mode.
//   cfg_* : strict_mode, written while the block is idle.
// An accepted request is registered in the input stage, and its results are
// then registered in the result queue. Plain text, with at most one result per
// byte, runs at a byte per cycle while out_stall is low. A failed partial entity
// releases up to six results from a six-entry result queue; the next byte waits
// in the input stage until the queue is down to its last entry.
// When out_stall is high the queue holds, the input stage fills and in_stall
// rises; nothing is lost. Reset clears the held entity, the drop flag, the
// queue and strict_mode.
// ----------------------------------------------------------------------------
module xml_entity_unescape (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  xeu_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output xeu_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic          cfg_wdata
);

	logic                      strict_q;
	logic                      vld_s1;
	xeu_pkg::in_t              in_s1;
	logic [xeu_pkg::CNT_W-1:0] mc_q;
	logic                      drop_q;
	logic [7:0]                mb_q [xeu_pkg::HOLD_DEPTH];
	xeu_pkg::out_t             rq_q [xeu_pkg::MAX_RES];
	logic [xeu_pkg::CNT_W-1:0] rq_cnt_q;

	xeu_pkg::step_ctl_t        ctl;
	xeu_pkg::out_t             res [xeu_pkg::MAX_RES];
	logic                      pop;
	logic                      load;
	logic                      accept;

	xeu_step u_step (
		.c      (in_s1.in_byte),
		.last   (in_s1.in_last),
		.strict (strict_q),
		.drop   (drop_q),
		.mc     (mc_q),
		.mb     (mb_q),
		.ctl    (ctl),
		.res    (res)
	);

	assign out_valid = (rq_cnt_q != '0);
	assign out_data  = rq_q[0];
	assign pop       = out_valid && !out_stall;
	// queue takes a new batch once its last entry leaves
	assign load      = vld_s1 && ((rq_cnt_q == '0) || (rq_cnt_q == 3'd1 && pop));
	assign in_stall  = vld_s1 && !load;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b0;
		end else if (cfg_we) begin
			strict_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (load) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			in_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q   <= '0;
			drop_q <= 1'b0;
		end else if (load) begin
			mc_q   <= ctl.mc_next;
			drop_q <= ctl.drop_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load && ctl.mb_we)
			mb_q[ctl.mb_idx] <= ctl.mb_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_cnt_q <= '0;
		end else if (load) begin
			rq_cnt_q <= ctl.res_cnt;
		end else if (pop) begin
			rq_cnt_q <= rq_cnt_q - xeu_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rq_q <= res;
		end else if (pop) begin
			for (int i = 0; i < xeu_pkg::MAX_RES - 1; i++)
				rq_q[i] <= rq_q[i+1];
		end
	end

endmodule

// ===== src/xeu_checker.sv =====
// ----------------------------------------------------------------------------
// XML entity decoder: port checker
// Concurrent checks on the top-level ports, bound into the decoder.
// ----------------------------------------------------------------------------
`include "xml_entity_unescape_defines.svh"

module xeu_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input xeu_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_stall,
	input xeu_pkg::out_t out_data,
	input logic          cfg_we
);

	// an error result always closes its message and carries a zero byte
	`XEU_ASSERT_NOW(a_err_closes, out_valid && out_data.bad_sequence, out_data.out_last && out_data.out_byte == 8'h00, "error result without last mark or with data")

	// with nothing waiting at the output the input side never stalls
	`XEU_ASSERT_NOW(a_no_idle_stall, !out_valid, !in_stall, "input stalled while output queue empty")

	// a stalled result holds
	`XEU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

	// a stalled request holds
	`XEU_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data), "stalled request changed")

	// mode only changes with both sides quiet
	`XEU_ASSERT_NOW(a_cfg_idle, cfg_we, !out_valid && !in_valid, "strict_mode written while busy")

endmodule

bind xml_entity_unescape xeu_checker u_xeu_checker (.*);

// ===== bench/xml_entity_unescape_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// XML entity decoder testbench
// Drives byte requests through the decoder in relaxed and strict mode,
// predicts every result from a behavioural decoder kept in step with the
// accepted requests, and checks each result as it leaves the block.
// ----------------------------------------------------------------------------
module xml_entity_unescape_tb;

	localparam int          LIMIT_CYCLES  = 400000;
	localparam int          SETTLE_CYCLES = 6;
	localparam int          HOLD_MAX      = 5;
	localparam logic [7:0]  CHR_AMP       = 8'h26;
	localparam logic [7:0]  CHR_LT        = 8'h3c;
	localparam logic [7:0]  CHR_GT        = 8'h3e;

	typedef enum logic [1:0] {SCAN_NONE, SCAN_PREFIX, SCAN_FULL} entity_scan_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	xeu_pkg::in_t  in_data;
	logic          out_valid;
	logic          out_stall = 1'b0;
	xeu_pkg::out_t out_data;
	logic          cfg_we;
	logic          cfg_wdata;

	// decoder state as predicted
	logic [7:0]    held_text [HOLD_MAX];
	int            held_cnt;
	logic          drop_rest;
	logic          strict_on;

	xeu_pkg::out_t pending_results [$];

	int in_gap_pct;
	int out_stall_pct;
	int stall_left = 0;
	int cycle_count = 0;
	int fail_count = 0;
	int items_sent;
	int live_items;
	int results_checked = 0;
	int errors_checked = 0;
	int entity_hits;

	xml_entity_unescape u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// entity decoding prediction
	// ------------------------------------------------------------------
	function automatic string entity_text(int idx);
		case (idx)
			0: return "&quot;";
			1: return "&apos;";
			2: return "&lt;";
			3: return "&gt;";
			default: return "&amp;";
		endcase
	endfunction

	function automatic logic [7:0] entity_char(int idx);
		case (idx)
			0: return 8'h22;
			1: return 8'h27;
			2: return CHR_LT;
			3: return CHR_GT;
			default: return CHR_AMP;
		endcase
	endfunction

	// held bytes followed by c, against every entity
	function automatic entity_scan_t entity_scan(logic [7:0] c, output logic [7:0] ch);
		entity_scan_t res;
		string        t;
		bit           same;
		int           n;
		res = SCAN_NONE;
		ch  = 8'h00;
		n   = held_cnt + 1;
		for (int e = 0; e < 5; e++) begin
			t = entity_text(e);
			if (n <= t.len()) begin
				same = 1'b1;
				for (int i = 0; i < n; i++)
					if (((i < held_cnt) ? held_text[i] : c) != t[i])
						same = 1'b0;
				if (same) begin
					if (n == t.len()) begin
						ch = entity_char(e);
						return SCAN_FULL;
					end
					res = SCAN_PREFIX;
				end
			end
		end
		return res;
	endfunction

	function automatic void push_result(logic [7:0] b, logic last, logic bad);
		xeu_pkg::out_t r;
		r.out_byte     = b;
		r.out_last     = last;
		r.bad_sequence = bad;
		pending_results.push_back(r);
	endfunction

	function automatic void raise_abort(logic last);
		push_result(8'h00, 1'b1, 1'b1);
		held_cnt  = 0;
		drop_rest = !last;
	endfunction

	function automatic void flush_held();
		if (strict_on) begin
			raise_abort(1'b1);
			return;
		end
		for (int i = 0; i < held_cnt; i++)
			push_result(held_text[i], (i + 1 == held_cnt), 1'b0);
		held_cnt = 0;
	endfunction

	// returns 0 when the byte was swallowed by an aborted message
	function automatic bit decode_byte(logic [7:0] c, logic last);
		entity_scan_t r;
		logic [7:0]   ch;
		if (drop_rest) begin
			if (last)
				drop_rest = 1'b0;
			return 1'b0;
		end
		if (held_cnt > 0) begin
			r = entity_scan(c, ch);
			if (r == SCAN_FULL) begin
				push_result(ch, last, 1'b0);
				held_cnt = 0;
				entity_hits++;
				return 1'b1;
			end
			if (r == SCAN_PREFIX && held_cnt < HOLD_MAX) begin
				held_text[held_cnt] = c;
				held_cnt++;
				if (last)
					flush_held();
				return 1'b1;
			end
			if (strict_on) begin
				raise_abort(last);
				return 1'b1;
			end
			// failed partial entity goes out as text, byte re-examined below
			for (int i = 0; i < held_cnt; i++)
				push_result(held_text[i], 1'b0, 1'b0);
			held_cnt = 0;
		end
		if (c == CHR_AMP) begin
			held_text[0] = c;
			held_cnt     = 1;
			if (last)
				flush_held();
		end else if (strict_on && (c == CHR_LT || c == CHR_GT)) begin
			raise_abort(last);
		end else begin
			push_result(c, last, 1'b0);
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// handshake helpers
	// ------------------------------------------------------------------
	// mostly short gaps, now and then a long one
	function automatic int pick_gap(int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) < 8)
			return $urandom_range(3, 1);
		return $urandom_range(25, 6);
	endfunction

	task automatic send_byte(input logic [7:0] value, input logic last);
		xeu_pkg::in_t req;
		int           gap;
		req.in_byte = value;
		req.in_last = last;
		gap = pick_gap(in_gap_pct);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (decode_byte(value, last))
			live_items++;
	endtask

	task automatic send_text(input string s, input logic last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], last_at_end && (i == s.len() - 1));
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// a held '&' gives no result, so let the pipeline settle before writing
	task automatic set_strict(input logic value);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		strict_on = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// output stall and result checking
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left == 0)
			stall_left = pick_gap(out_stall_pct);
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : result_check
		xeu_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result byte %02h last %0b bad %0b", $time,
					out_data.out_byte, out_data.out_last, out_data.bad_sequence);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (want.bad_sequence)
					errors_checked++;
				if (out_data.out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %02h got %02h", $time,
						want.out_byte, out_data.out_byte);
					fail_count++;
				end
				if (out_data.out_last !== want.out_last) begin
					$display("%0t: out_last expected %0b got %0b", $time,
						want.out_last, out_data.out_last);
					fail_count++;
				end
				if (out_data.bad_sequence !== want.bad_sequence) begin
					$display("%0t: bad_sequence expected %0b got %0b", $time,
						want.bad_sequence, out_data.bad_sequence);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: run limit reached, %0d results outstanding", $time,
				pending_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_relaxed_decode();
		set_strict(1'b0);
		in_gap_pct    = 25;
		out_stall_pct = 25;
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_text("&lt;", 1'b1);
		// full five-byte hold fails on '&', which starts a new match
		send_text("&apos&", 1'b0);
		send_text("x", 1'b1);
		// partial entity flushed at end of message
		send_text("&am", 1'b1);
	endtask

	task automatic test_strict_rejects();
		set_strict(1'b1);
		send_text("<", 1'b0);
		send_text("z", 1'b1);
		send_text("&gt>q", 1'b1);
		send_text(">", 1'b1);
		send_text("&", 1'b1);
		send_text("&quot;", 1'b1);
	endtask

	task automatic test_mode_change_mid_message();
		set_strict(1'b1);
		send_text(">", 1'b0);
		// relaxing the mode must not end the drop, only the last mark does
		set_strict(1'b0);
		send_text("a", 1'b1);
		send_text("&a", 1'b0);
		set_strict(1'b1);
		send_text("x", 1'b0);
		send_text("y", 1'b1);
	endtask

	function automatic void add_token(ref logic [7:0] msg[$]);
		int    kind;
		int    n;
		string t;
		kind = $urandom_range(99);
		t    = entity_text($urandom_range(4));
		if (kind < 35) begin
			msg.push_back(8'($urandom_range(25) + 97));
		end else if (kind < 60) begin
			for (int i = 0; i < t.len(); i++)
				msg.push_back(t[i]);
		end else if (kind < 72) begin
			n = $urandom_range(t.len() - 1, 1);
			for (int i = 0; i < n; i++)
				msg.push_back(t[i]);
		end else if (kind < 80) begin
			msg.push_back($urandom_range(1) ? CHR_LT : CHR_GT);
		end else if (kind < 90) begin
			msg.push_back(8'($urandom()));
		end else if (kind < 94) begin
			msg.push_back(8'h00);
		end else begin
			// longest hold followed by an arbitrary byte, which usually breaks it
			t = entity_text($urandom_range(1));
			for (int i = 0; i < HOLD_MAX; i++)
				msg.push_back(t[i]);
			msg.push_back(8'($urandom()));
		end
	endfunction

	task automatic run_random_phase(input int goal, input int gap_pct, input int stall_pct,
		input bit pause_midway);
		logic [7:0] msg [$];
		int         start;
		bit         paused;
		in_gap_pct    = gap_pct;
		out_stall_pct = stall_pct;
		start  = items_sent;
		paused = 1'b0;
		while (items_sent - start < goal) begin
			msg.delete();
			repeat ($urandom_range(8, 1))
				add_token(msg);
			for (int i = 0; i < msg.size(); i++)
				send_byte(msg[i], i == msg.size() - 1);
			if (pause_midway && !paused && items_sent - start >= goal / 2) begin
				drain_results();
				paused = 1'b1;
			end
		end
	endtask

	task automatic test_random_traffic();
		set_strict(1'b0);
		run_random_phase(40, 30, 30, 1'b0);
		set_strict(1'b1);
		run_random_phase(40, 30, 30, 1'b0);
		set_strict(1'b0);
		run_random_phase(30, 0, 0, 1'b0);
		set_strict(1'b1);
		run_random_phase(40, 40, 60, 1'b1);
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_we        = 1'b0;
		cfg_wdata     = 1'b0;
		held_cnt      = 0;
		drop_rest     = 1'b0;
		strict_on     = 1'b0;
		in_gap_pct    = 0;
		out_stall_pct = 0;
		items_sent    = 0;
		live_items    = 0;
		entity_hits     = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_relaxed_decode();
		test_strict_rejects();
		test_mode_change_mid_message();
		test_random_traffic();

		drain_results();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d requests (%0d not swallowed by aborts), checked %0d results, %0d errors.",
			items_sent, live_items, results_checked, errors_checked);
		$display("Covered relaxed and strict mode, %0d whole entities, flushes and port stalls.",
			entity_hits);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/xeu_pkg.sv
src/xeu_step.sv
src/xml_entity_unescape.sv
src/xeu_checker.sv
bench/xml_entity_unescape_tb.sv
